@@ rtl/bank_switch_scanline_irq_mapper_defines.svh @@
// assertion macros shared by the mapper checker
// no dependencies
`ifndef BANK_SWITCH_SCANLINE_IRQ_MAPPER_DEFINES_SVH
`define BANK_SWITCH_SCANLINE_IRQ_MAPPER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BSSIM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bssim: implication check failed");

// next-cycle implication, disabled in reset
`define BSSIM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bssim: next-cycle check failed");

`endif

@@ rtl/bssim_pkg.sv @@
// types and constants for the bank switch scanline irq mapper
// no dependencies
package bssim_pkg;

   typedef enum logic [0:0] {
      OP_CPU_WRITE  = 1'b0,
      OP_VIDEO_READ = 1'b1
   } opcode_type;

   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int COUNT_W    = 7;
   localparam int BANK_W     = 8;
   localparam int NUM_BANKS  = 8;
   localparam int BANK_IDX_W = 3;
   localparam int FILTER_W   = 16;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [BANK_W-1:0]  bank_type;

   // cpu write decode
   localparam addr_type DECODE_MASK     = 16'hE001;
   localparam addr_type REG_BANK_SELECT = 16'h8000;
   localparam addr_type REG_BANK_DATA   = 16'h8001;
   localparam addr_type REG_MIRROR      = 16'hA000;
   localparam addr_type REG_IRQ_LATCH   = 16'hC000;
   localparam addr_type REG_IRQ_RELOAD  = 16'hC001;
   localparam addr_type REG_IRQ_DISABLE = 16'hE000;
   localparam addr_type REG_IRQ_ENABLE  = 16'hE001;

   // video side
   localparam addr_type PALETTE_BASE = 16'h3F00;
   localparam int       A12_BIT      = 12;

   localparam logic [FILTER_W-1:0] FILTER_LOAD = 16'h8000;
   localparam count_type           PRG_COUNT_RESET = 7'd32;

endpackage

@@ rtl/bssim_if.sv @@
// valid/ready channel interfaces for mapper requests and responses
// depends on bssim_pkg
interface bssim_req_if;
   import bssim_pkg::*;
   logic       valid;
   logic       ready;
   opcode_type opcode;
   addr_type   address;
   data_type   write_data;

   modport source (output valid, output opcode, output address, output write_data,
                   input ready);
   modport sink   (input valid, input opcode, input address, input write_data,
                   output ready);
endinterface

interface bssim_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] prg_banks;
   logic [63:0] chr_banks;
   logic        mirror_vertical;
   logic        irq_line;

   modport source (output valid, output prg_banks, output chr_banks,
                   output mirror_vertical, output irq_line, input ready);
   modport sink   (input valid, input prg_banks, input chr_banks,
                   input mirror_vertical, input irq_line, output ready);
endinterface

@@ rtl/bank_switch_scanline_irq_mapper.sv @@
// a request passes the input register, then the result register, before its response is valid
// throughput: one transfer per cycle; the only stall comes from a held response
// the register decode, scanline counter and bank muxes are combinational between the two registers
// reset: synchronous active high, restores all mapper registers and empties
// both pipeline stages; prg bank count returns to 32
module bank_switch_scanline_irq_mapper (
   input  logic                  clock,
   input  logic                  reset,
   bssim_req_if.sink             req_if,
   bssim_rsp_if.source           rsp_if,
   input  logic                  csr_write_enable,
   input  bssim_pkg::count_type  csr_write_data
);
   import bssim_pkg::*;

   // input stage
   logic       in_valid_ff;
   opcode_type in_opcode_ff;
   addr_type   in_address_ff;
   data_type   in_data_ff;

   // result stage
   logic        out_valid_ff;
   logic [31:0] out_prg_ff, out_prg_in;
   logic [63:0] out_chr_ff, out_chr_in;
   logic        out_mirror_ff;
   logic        out_irq_ff;

   // mapper state
   count_type             prg_count_ff;
   bank_type              bank_regs_ff [NUM_BANKS];
   bank_type              bank_regs_in [NUM_BANKS];
   logic [BANK_IDX_W-1:0] bank_index_ff, bank_index_in;
   logic                  prg_mode_ff, prg_mode_in;
   logic                  chr_mode_ff, chr_mode_in;
   logic                  mirror_ff, mirror_in;
   bank_type              reload_latch_ff, reload_latch_in;
   bank_type              counter_ff, counter_in;
   logic                  reload_req_ff, reload_req_in;
   logic                  irq_enable_ff, irq_enable_in;
   logic                  irq_pending_ff, irq_pending_in;
   logic [FILTER_W-1:0]   filter_ff, filter_in;
   logic                  last_a12_ff, last_a12_in;

   logic     advance;
   logic     do_step;
   logic     a12;
   addr_type decoded;
   bank_type fix2, fix1;
   bank_type r0lo, r0hi, r1lo, r1hi;

   // the result register frees up when empty or when its transfer completes
   assign advance       = !out_valid_ff || rsp_if.ready;
   assign req_if.ready  = !in_valid_ff || advance;
   assign do_step       = in_valid_ff && advance;

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.prg_banks       = out_prg_ff;
   assign rsp_if.chr_banks       = out_chr_ff;
   assign rsp_if.mirror_vertical = out_mirror_ff;
   assign rsp_if.irq_line        = out_irq_ff;

   assign decoded = in_address_ff & DECODE_MASK;
   assign a12     = in_address_ff[A12_BIT];

   // state update for the item in the input register
   always_comb begin
      bank_regs_in    = bank_regs_ff;
      bank_index_in   = bank_index_ff;
      prg_mode_in     = prg_mode_ff;
      chr_mode_in     = chr_mode_ff;
      mirror_in       = mirror_ff;
      reload_latch_in = reload_latch_ff;
      counter_in      = counter_ff;
      reload_req_in   = reload_req_ff;
      irq_enable_in   = irq_enable_ff;
      irq_pending_in  = irq_pending_ff;
      filter_in       = filter_ff;
      last_a12_in     = last_a12_ff;
      if (do_step) begin
         if (in_opcode_ff == OP_CPU_WRITE) begin
            unique case (decoded)
               REG_BANK_SELECT: begin
                  bank_index_in = in_data_ff[BANK_IDX_W-1:0];
                  prg_mode_in   = in_data_ff[6];
                  chr_mode_in   = in_data_ff[7];
               end
               REG_BANK_DATA: begin
                  bank_regs_in[bank_index_ff] = in_data_ff;
               end
               REG_MIRROR: begin
                  mirror_in = in_data_ff[0];
               end
               REG_IRQ_LATCH: begin
                  reload_latch_in = in_data_ff;
               end
               REG_IRQ_RELOAD: begin
                  reload_req_in = 1'b1;
               end
               REG_IRQ_DISABLE: begin
                  irq_enable_in  = 1'b0;
                  irq_pending_in = 1'b0;
               end
               REG_IRQ_ENABLE: begin
                  irq_enable_in = 1'b1;
               end
               default: begin
               end
            endcase
         end else if (in_address_ff < PALETTE_BASE) begin
            // palette reads leave the counter and filter untouched
            if (!last_a12_ff && a12) begin
               if (filter_ff == '0) begin
                  // reload on zero or on request, else count down
                  if (counter_ff == '0 || reload_req_ff) begin
                     counter_in    = reload_latch_ff;
                     reload_req_in = 1'b0;
                  end else begin
                     counter_in = counter_ff - 8'd1;
                  end
                  if (counter_in == '0 && irq_enable_ff) begin
                     irq_pending_in = 1'b1;
                  end
               end
               // every rising edge rearms the filter, filtered or not
               filter_in = FILTER_LOAD;
            end else begin
               filter_in = filter_ff >> 1;
            end
            last_a12_in = a12;
         end
      end
   end

   // bank mapping seen after this item; fixed banks wrap modulo 256
   assign fix2 = {1'b0, prg_count_ff} - 8'd2;
   assign fix1 = {1'b0, prg_count_ff} - 8'd1;
   assign r0lo = bank_regs_in[0] & 8'hFE;
   assign r0hi = bank_regs_in[0] | 8'h01;
   assign r1lo = bank_regs_in[1] & 8'hFE;
   assign r1hi = bank_regs_in[1] | 8'h01;

   always_comb begin
      if (!prg_mode_in) begin
         out_prg_in = {fix1, fix2, bank_regs_in[7], bank_regs_in[6]};
      end else begin
         out_prg_in = {fix1, bank_regs_in[6], bank_regs_in[7], fix2};
      end
      // 2K pairs and 1K slots trade halves with the chr mode
      if (!chr_mode_in) begin
         out_chr_in = {bank_regs_in[5], bank_regs_in[4], bank_regs_in[3], bank_regs_in[2],
                       r1hi, r1lo, r0hi, r0lo};
      end else begin
         out_chr_in = {r1hi, r1lo, r0hi, r0lo,
                       bank_regs_in[5], bank_regs_in[4], bank_regs_in[3], bank_regs_in[2]};
      end
   end

   // pipeline control and mapper state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         prg_count_ff    <= PRG_COUNT_RESET;
         for (int i = 0; i < NUM_BANKS; i++) begin
            bank_regs_ff[i] <= (i == NUM_BANKS - 1) ? 8'd1 : 8'd0;
         end
         bank_index_ff   <= '0;
         prg_mode_ff     <= 1'b0;
         chr_mode_ff     <= 1'b0;
         mirror_ff       <= 1'b0;
         reload_latch_ff <= '0;
         counter_ff      <= '0;
         reload_req_ff   <= 1'b0;
         irq_enable_ff   <= 1'b0;
         irq_pending_ff  <= 1'b0;
         filter_ff       <= '0;
         last_a12_ff     <= 1'b0;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (csr_write_enable) begin
            prg_count_ff <= csr_write_data;
         end
         bank_regs_ff    <= bank_regs_in;
         bank_index_ff   <= bank_index_in;
         prg_mode_ff     <= prg_mode_in;
         chr_mode_ff     <= chr_mode_in;
         mirror_ff       <= mirror_in;
         reload_latch_ff <= reload_latch_in;
         counter_ff      <= counter_in;
         reload_req_ff   <= reload_req_in;
         irq_enable_ff   <= irq_enable_in;
         irq_pending_ff  <= irq_pending_in;
         filter_ff       <= filter_in;
         last_a12_ff     <= last_a12_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_opcode_ff  <= req_if.opcode;
         in_address_ff <= req_if.address;
         in_data_ff    <= req_if.write_data;
      end
      if (do_step) begin
         out_prg_ff    <= out_prg_in;
         out_chr_ff    <= out_chr_in;
         out_mirror_ff <= mirror_in;
         out_irq_ff    <= irq_pending_in;
      end
   end

endmodule

@@ rtl/bssim_checker.sv @@
// port-level checks for the mapper, attached to the mapper by bind
// depends on bank_switch_scanline_irq_mapper_defines.svh
`include "bank_switch_scanline_irq_mapper_defines.svh"

module bssim_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_prg_banks,
   input logic [63:0] rsp_chr_banks,
   input logic        rsp_mirror_vertical,
   input logic        rsp_irq_line
);

   // a stalled response keeps its valid
   `BSSIM_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled response keeps its payload
   `BSSIM_ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_prg_banks) && $stable(rsp_chr_banks) && $stable(rsp_mirror_vertical) && $stable(rsp_irq_line))

   // request side only backs up behind a stalled response
   `BSSIM_ASSERT_IMPLIES(a_req_backpressure, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // a fresh response follows a request transfer through the input and result registers
   `BSSIM_ASSERT_IMPLIES(a_rsp_latency, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))

endmodule

bind bank_switch_scanline_irq_mapper bssim_checker u_bssim_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_prg_banks       (rsp_if.prg_banks),
   .rsp_chr_banks       (rsp_if.chr_banks),
   .rsp_mirror_vertical (rsp_if.mirror_vertical),
   .rsp_irq_line        (rsp_if.irq_line)
);
